// File: sv/bwst_pkg.sv
// ----------------------------------------------------------------------------
// bwst_pkg: shared types and constants for the barrier wait-set tracker
// Field widths, operation codes, the reset value and the item/result structs.
// ----------------------------------------------------------------------------
package bwst_pkg;

  // Default number of tracked threads
  localparam int THREAD_COUNT_DEF = 32;

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int TID_W  = 5;
  localparam int WCNT_W = 6;
  localparam int POP_W  = 6;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_WAIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Wait count after reset
  localparam logic [WCNT_W-1:0] WAIT_COUNT_RST = 6'd32;

  // One request item
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TID_W-1:0]  thread_id;
  } item_t;

  // One result item
  typedef struct packed {
    logic             would_block;
    logic             was_waiting;
    logic             released;
    logic [POP_W-1:0] current_population;
  } res_t;

endpackage

// File: sv/bwst_in_stage.sv
// ----------------------------------------------------------------------------
// bwst_in_stage: input register
// Captures one request item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module bwst_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bwst_pkg::item_t in_item,
  input  logic            adv,
  output logic            s1_valid,
  output bwst_pkg::item_t s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  bwst_pkg::item_t item_r;

  // Take a new item when empty or when the held one moves on this cycle
  assign in_ready  = !valid_r || adv;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !adv);

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: sv/bwst_core.sv
// ----------------------------------------------------------------------------
// bwst_core: barrier state and per-item update
// Holds both parity bitmaps, their population counters, the parity flag and
// the wait count; applies one wait, leave or query per advancing item.
// ----------------------------------------------------------------------------
module bwst_core #(
  parameter int THREAD_COUNT = bwst_pkg::THREAD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bwst_pkg::WCNT_W-1:0] cfg_wr_data,
  input  logic                        adv,
  input  bwst_pkg::item_t             item,
  output bwst_pkg::res_t              res
);

  localparam int PW = $clog2(THREAD_COUNT + 1);
  localparam int CW = (PW > bwst_pkg::WCNT_W) ? PW : bwst_pkg::WCNT_W;

  logic [THREAD_COUNT-1:0]     even_r, even_nxt;
  logic [THREAD_COUNT-1:0]     odd_r, odd_nxt;
  logic [PW-1:0]               pop_even_r, pop_even_nxt;
  logic [PW-1:0]               pop_odd_r, pop_odd_nxt;
  logic                        parity_r, parity_nxt;
  logic [bwst_pkg::WCNT_W-1:0] wait_count_r;

  logic [THREAD_COUNT-1:0] sel;
  logic                    hit;
  logic                    in_even;
  logic                    in_odd;
  logic                    waiting;
  logic [PW-1:0]           cur_pop;
  logic [PW-1:0]           ins_pop;
  logic [PW-1:0]           pop_after;
  logic                    blk;
  logic                    rel;

  // Decode the thread into a one-hot mask; out-of-range threads select nothing
  always_comb begin
    for (int i = 0; i < THREAD_COUNT; i++) begin
      sel[i] = (int'(item.thread_id) == i);
    end
  end

  assign hit     = |sel;
  assign in_even = |(even_r & sel);
  assign in_odd  = |(odd_r & sel);
  assign waiting = in_even || in_odd;
  assign cur_pop = parity_r ? pop_even_r : pop_odd_r;
  assign ins_pop = cur_pop + PW'(1);

  // Apply the operation to the sets, counters and parity
  always_comb begin
    even_nxt     = even_r;
    odd_nxt      = odd_r;
    pop_even_nxt = pop_even_r;
    pop_odd_nxt  = pop_odd_r;
    parity_nxt   = parity_r;
    blk          = 1'b0;
    rel          = 1'b0;
    unique case (item.mode)
      bwst_pkg::MODE_WAIT: begin
        if (hit && !waiting) begin
          if (parity_r) begin
            even_nxt     = even_r | sel;
            pop_even_nxt = ins_pop;
          end else begin
            odd_nxt     = odd_r | sel;
            pop_odd_nxt = ins_pop;
          end
          if (CW'(ins_pop) == CW'(wait_count_r)) begin
            parity_nxt = !parity_r;
            rel        = 1'b1;
          end
        end
      end
      bwst_pkg::MODE_LEAVE: begin
        even_nxt     = even_r & ~sel;
        odd_nxt      = odd_r & ~sel;
        pop_even_nxt = pop_even_r - PW'(in_even);
        pop_odd_nxt  = pop_odd_r - PW'(in_odd);
      end
      bwst_pkg::MODE_QUERY: begin
        if (waiting && (in_even != parity_r)) begin
          blk = 1'b0;
        end else begin
          blk = CW'(cur_pop) < CW'(wait_count_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Report the current-parity population after the operation
  assign pop_after = parity_nxt ? pop_even_nxt : pop_odd_nxt;

  always_comb begin
    res.would_block        = blk;
    res.was_waiting        = waiting;
    res.released           = rel;
    res.current_population = bwst_pkg::POP_W'(pop_after);
  end

  // Commit state when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_r     <= '0;
      odd_r      <= '0;
      pop_even_r <= '0;
      pop_odd_r  <= '0;
      parity_r   <= 1'b1;
    end else if (adv) begin
      even_r     <= even_nxt;
      odd_r      <= odd_nxt;
      pop_even_r <= pop_even_nxt;
      pop_odd_r  <= pop_odd_nxt;
      parity_r   <= parity_nxt;
    end
  end

  // Hold the wait count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_count_r <= bwst_pkg::WAIT_COUNT_RST;
    end else if (cfg_wr_en) begin
      wait_count_r <= cfg_wr_data;
    end
  end

`ifndef SYNTHESIS
  a_even_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(even_r) == int'(pop_even_r))
    else $error("even population counter out of step with bitmap");

  a_odd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(odd_r) == int'(pop_odd_r))
    else $error("odd population counter out of step with bitmap");

  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (even_r & odd_r) == '0)
    else $error("thread present in both parity sets");

  a_release_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rel) |=> (parity_r != $past(parity_r)))
    else $error("release without parity flip");
`endif

endmodule

// File: sv/bwst_out_stage.sv
// ----------------------------------------------------------------------------
// bwst_out_stage: result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module bwst_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  bwst_pkg::res_t res,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output bwst_pkg::res_t out_res
);

  logic           valid_r;
  logic           valid_nxt;
  bwst_pkg::res_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign space     = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: sv/barrier_wait_set_tracker.sv
// ----------------------------------------------------------------------------
// barrier_wait_set_tracker: sense-reversing barrier wait-set tracker
// Request channel in_*: mode (wait, leave, query) and thread_id, valid/ready.
// Result channel out_*: would_block, was_waiting, released and the
// current-parity population after the operation, valid/ready.
// Config port cfg_*: cfg_wr_en writes cfg_wr_data into the wait count at the
// clock edge, no wait states; write it only while the block is idle.
// Path: an accepted item passes the input register, then the update logic
// into the result register, where its result becomes valid.
// Throughput: one item per cycle while out_ready keeps the result register
// free; the state update of each item is done in the update logic between
// the input register and the result register.
// Reset (synchronous, rst_n low): both sets empty, parity even, wait count
// 32, both registers empty.
// Stall: when out_ready is low the result holds; the input register still
// takes one more item, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module barrier_wait_set_tracker #(
  parameter int THREAD_COUNT = bwst_pkg::THREAD_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bwst_pkg::MODE_W-1:0] in_mode,
  input  logic [bwst_pkg::TID_W-1:0]  in_thread_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_would_block,
  output logic                        out_was_waiting,
  output logic                        out_released,
  output logic [bwst_pkg::POP_W-1:0]  out_current_population,
  input  logic                        cfg_wr_en,
  input  logic [bwst_pkg::WCNT_W-1:0] cfg_wr_data
);

  bwst_pkg::item_t in_item;
  bwst_pkg::item_t s1_item;
  bwst_pkg::res_t  core_res;
  bwst_pkg::res_t  out_res;
  logic            s1_valid;
  logic            out_space;
  logic            adv;

  // Pack the request fields
  always_comb begin
    in_item.mode      = in_mode;
    in_item.thread_id = in_thread_id;
  end

  // Advance the held item when the result register has room
  assign adv = s1_valid && out_space;

  bwst_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  bwst_core #(
    .THREAD_COUNT (THREAD_COUNT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .item        (s1_item),
    .res         (core_res)
  );

  bwst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (core_res),
    .space     (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Unpack the result fields
  assign out_would_block        = out_res.would_block;
  assign out_was_waiting        = out_res.was_waiting;
  assign out_released           = out_res.released;
  assign out_current_population = out_res.current_population;

endmodule
